>>> src/gyro_angle_integrator_autocal_defines.svh
// Assertion macros used by the top RTL file of the gyro integrator.
`ifndef GYRO_ANGLE_INTEGRATOR_AUTOCAL_DEFINES_SVH
`define GYRO_ANGLE_INTEGRATOR_AUTOCAL_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GAIC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gaic: assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define GAIC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gaic: assertion failed");

`endif

>>> src/gaic_pkg.sv
package gaic_pkg;

    localparam int RAW_W    = 16;
    localparam int TS_W     = 32;
    localparam int ANGLE_W  = 48;
    localparam int OFFS_W   = 24;
    localparam int DEADB_W  = 23;
    localparam int CNT_W    = 16;
    localparam int SUM_W    = 40;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam int DIV_N_W  = SUM_W;
    localparam int DIV_D_W  = CNT_W;
    localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

    localparam logic [TS_W-1:0] MAX_STEP_US_DEF = 32'd1048575;

    localparam logic [DEADB_W-1:0] DEADBAND_RST = 23'd12800;
    localparam logic [CNT_W-1:0]   CALIB_RST    = 16'd2000;
    localparam logic [CNT_W-1:0]   MIN_BIAS_RST = 16'd26;

    // Drift is in raw*us, the mean in Q8 raw units: compare drift*256 with mean*1e6.
    localparam logic [19:0] DRIFT_SCALE = 20'd1000000;

    localparam logic [CFG_IDX_W-1:0] REG_INIT_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AUTOCAL     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CALIB_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_BIAS    = 3'd4;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

>>> src/gyro_angle_integrator_autocal.sv
// A clear word goes straight to the output state; a rate sample passes the multiply,
// accumulate and calibrate states, and when autocalibration runs its mean it also goes
// through a 40-step serial divider and a compare state. The block takes one word at a
// time; s_tready returns as the result is loaded into the output register, and a
// stalled output word holds the block longer.
// Reset (rst_n low, asynchronous) zeroes angle, offset, averages and history and
// loads the register defaults; no clearing pass follows.
`include "gyro_angle_integrator_autocal_defines.svh"

module gyro_angle_integrator_autocal
#(
    parameter logic [gaic_pkg::TS_W-1:0] MAX_STEP_US = gaic_pkg::MAX_STEP_US_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // gyro_raw[15:0], timestamp_us[47:16]
    input  logic [0:0]  s_tuser,   // mode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // angle[47:0], bias_offset_q8[71:48]
    output logic [1:0]  m_tuser,   // in_deadband[0], recalibrated[1]
    input  logic        cfg_we,
    input  logic [gaic_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gaic_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = gaic_pkg::ANGLE_W;
    localparam int OW = gaic_pkg::OFFS_W;
    localparam int SW = gaic_pkg::SUM_W;
    localparam int CW = gaic_pkg::CNT_W;
    localparam int TW = gaic_pkg::TS_W;
    localparam int VW = OW + 1;
    localparam int PW = VW + 1 + TW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_CAL,
        ST_DIV,
        ST_CMP,
        ST_OUT
    } state_t;

    state_t state_reg;

    logic signed [AW-1:0] angle_reg;
    logic signed [OW-1:0] offset_reg;
    logic signed [15:0]   prev_raw_reg;
    logic [TW-1:0]        prev_ts_reg;
    logic signed [SW-1:0] bsum_reg;
    logic [CW-1:0]        bcnt_reg;
    logic signed [AW-1:0] ref_reg;

    logic [gaic_pkg::DEADB_W-1:0] deadband_reg;
    logic                         autocal_reg;
    logic [CW-1:0]                calib_reg;
    logic [CW-1:0]                minb_reg;

    logic [VW:0]          smag_reg;
    logic                 sneg_reg;
    logic [TW-1:0]        dt_reg;
    logic signed [VW-1:0] v2_reg;
    logic                 dead_reg;
    logic                 recal_reg;
    logic [PW-1:0]        prod_reg;
    logic [SW-1:0]        mm_reg;
    logic [AW:0]          drift_reg;

    logic                 out_valid_reg;
    logic [71:0]          out_data_reg;
    logic [1:0]           out_user_reg;

    // Sample path.
    logic signed [15:0]   raw_in;
    logic [TW-1:0]        ts_in;
    logic [TW-1:0]        dt_raw;
    logic signed [VW-1:0] v1_c;
    logic signed [VW-1:0] v2_c;
    logic signed [VW:0]   s_c;
    logic [VW-1:0]        v2_mag;

    assign raw_in = s_tdata[15:0];
    assign ts_in  = s_tdata[47:16];
    assign dt_raw = ts_in - prev_ts_reg;
    assign v1_c   = {prev_raw_reg[15], prev_raw_reg, 8'b0} + VW'(offset_reg);
    assign v2_c   = {raw_in[15], raw_in, 8'b0} + VW'(offset_reg);
    assign s_c    = (VW+1)'(v1_c) + (VW+1)'(v2_c);
    assign v2_mag = v2_c[VW-1] ? VW'(-v2_c) : VW'(v2_c);

    // Rounded area and saturating angle update.
    logic [PW-1:0]        psum;
    logic [AW:0]          q_c;
    logic signed [AW+1:0] area_c;
    logic signed [AW+1:0] asum_c;
    logic signed [AW-1:0] angle_sat;

    assign psum   = prod_reg + PW'(256);
    assign q_c    = psum[AW+9:9];
    assign area_c = sneg_reg ? -(AW+2)'({1'b0, q_c}) : (AW+2)'({1'b0, q_c});
    assign asum_c = (AW+2)'(angle_reg) + area_c;

    always_comb
    begin
        if (asum_c[AW+1:AW-1] == 3'b000 || asum_c[AW+1:AW-1] == 3'b111)
            angle_sat = asum_c[AW-1:0];
        else if (asum_c[AW+1])
            angle_sat = {1'b1, {(AW-1){1'b0}}};
        else
            angle_sat = {1'b0, {(AW-1){1'b1}}};
    end

    // Saturating bias sum.
    logic signed [SW:0]   bsum_c;
    logic signed [SW-1:0] bsum_sat;

    assign bsum_c = (SW+1)'(bsum_reg) + (SW+1)'(v2_reg);

    always_comb
    begin
        if (bsum_c[SW] == bsum_c[SW-1])
            bsum_sat = bsum_c[SW-1:0];
        else if (bsum_c[SW])
            bsum_sat = {1'b1, {(SW-1){1'b0}}};
        else
            bsum_sat = {1'b0, {(SW-1){1'b1}}};
    end

    // Mean, drift test and offset update.
    logic [SW-1:0]        bsum_mag;
    logic signed [AW:0]   rdiff_c;
    logic [59:0]          lhs_c;
    logic [59:0]          rhs_c;
    logic signed [SW:0]   mean_c;
    logic signed [SW+1:0] odiff_c;
    logic signed [OW-1:0] offset_sat;

    assign bsum_mag = bsum_reg[SW-1] ? SW'(-bsum_reg) : SW'(bsum_reg);
    assign rdiff_c  = (AW+1)'(ref_reg) - (AW+1)'(angle_reg);
    assign lhs_c    = {3'b0, drift_reg, 8'b0};
    assign rhs_c    = 60'(mm_reg) * 60'(gaic_pkg::DRIFT_SCALE);
    assign mean_c   = bsum_reg[SW-1] ? -(SW+1)'({1'b0, mm_reg}) : (SW+1)'({1'b0, mm_reg});
    assign odiff_c  = (SW+2)'(offset_reg) - (SW+2)'(mean_c);

    always_comb
    begin
        if (odiff_c[SW+1:OW-1] == '0 || odiff_c[SW+1:OW-1] == '1)
            offset_sat = odiff_c[OW-1:0];
        else if (odiff_c[SW+1])
            offset_sat = {1'b1, {(OW-1){1'b0}}};
        else
            offset_sat = {1'b0, {(OW-1){1'b1}}};
    end

    logic                  div_start;
    logic [SW-1:0]         div_quot;
    gaic_pkg::div_status_t div_sts;

    assign div_start = (state_reg == ST_CAL) && autocal_reg && (bcnt_reg != '0);

    gaic_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (bsum_mag),
        .divisor  (bcnt_reg),
        .quotient (div_quot),
        .status   (div_sts)
    );

    logic in_acc;
    logic out_load;

    assign in_acc   = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            angle_reg     <= '0;
            offset_reg    <= '0;
            prev_raw_reg  <= '0;
            prev_ts_reg   <= '0;
            bsum_reg      <= '0;
            bcnt_reg      <= '0;
            ref_reg       <= '0;
            deadband_reg  <= gaic_pkg::DEADBAND_RST;
            autocal_reg   <= 1'b0;
            calib_reg     <= gaic_pkg::CALIB_RST;
            minb_reg      <= gaic_pkg::MIN_BIAS_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        recal_reg <= 1'b0;
                        if (s_tuser[0] == gaic_pkg::MODE_CLEAR)
                        begin
                            dead_reg  <= 1'b0;
                            angle_reg <= '0;
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            dead_reg     <= (v2_mag <= VW'(deadband_reg));
                            smag_reg     <= s_c[VW] ? (VW+1)'(-s_c) : (VW+1)'(s_c);
                            sneg_reg     <= s_c[VW];
                            dt_reg       <= (dt_raw > MAX_STEP_US) ? MAX_STEP_US : dt_raw;
                            v2_reg       <= v2_c;
                            prev_raw_reg <= raw_in;
                            prev_ts_reg  <= ts_in;
                            state_reg    <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    prod_reg  <= PW'(smag_reg) * PW'(dt_reg);
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (dead_reg)
                    begin
                        bsum_reg <= bsum_sat;
                        if (bcnt_reg != '1)
                            bcnt_reg <= bcnt_reg + 1'b1;
                    end
                    else
                    begin
                        angle_reg <= angle_sat;
                    end
                    state_reg <= ST_CAL;
                end
                ST_CAL:
                begin
                    drift_reg <= rdiff_c[AW] ? (AW+1)'(-rdiff_c) : (AW+1)'(rdiff_c);
                    state_reg <= div_start ? ST_DIV : ST_OUT;
                end
                ST_DIV:
                begin
                    if (div_sts.done)
                    begin
                        mm_reg    <= div_quot;
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP:
                begin
                    if (lhs_c > rhs_c)
                    begin
                        bsum_reg <= '0;
                        bcnt_reg <= '0;
                        ref_reg  <= angle_reg;
                    end
                    else if (bcnt_reg >= calib_reg && mm_reg > SW'(minb_reg))
                    begin
                        offset_reg <= offset_sat;
                        bsum_reg   <= '0;
                        bcnt_reg   <= '0;
                        recal_reg  <= 1'b1;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        out_data_reg  <= {offset_reg, angle_reg};
                        out_user_reg  <= {recal_reg, dead_reg};
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // Writes to the initial offset register are ignored; reset clears the offset.
            if (cfg_we)
            begin
                unique case (cfg_index)
                    gaic_pkg::REG_DEADBAND:
                        deadband_reg <= cfg_data[gaic_pkg::DEADB_W-1:0];
                    gaic_pkg::REG_AUTOCAL:
                    begin
                        autocal_reg <= cfg_data[0];
                        if (cfg_data[0])
                        begin
                            bsum_reg <= '0;
                            bcnt_reg <= '0;
                        end
                    end
                    gaic_pkg::REG_CALIB_COUNT:
                        calib_reg <= cfg_data[CW-1:0];
                    gaic_pkg::REG_MIN_BIAS:
                        minb_reg <= cfg_data[CW-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `GAIC_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_tready)
    `GAIC_ASSERT_NOW(a_div_done_in_wait, div_sts.done, state_reg == ST_DIV)
    `GAIC_ASSERT_NOW(a_recal_needs_autocal, m_tvalid && m_tuser[1], autocal_reg)

endmodule

>>> src/gaic_div.sv
module gaic_div
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [gaic_pkg::DIV_N_W-1:0]  dividend,
    input  logic [gaic_pkg::DIV_D_W-1:0]  divisor,
    output logic [gaic_pkg::DIV_N_W-1:0]  quotient,
    output gaic_pkg::div_status_t         status
);

    localparam int NW = gaic_pkg::DIV_N_W;
    localparam int DW = gaic_pkg::DIV_D_W;
    localparam int CW = gaic_pkg::DIV_CNT_W;

    logic [NW-1:0] work_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] div_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [DW:0]   trial;
    logic          fits;
    logic [DW:0]   diff;

    // One restoring step per cycle: quotient bits shift in where dividend bits leave.
    assign trial = {rem_reg, work_reg[NW-1]};
    assign fits  = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                work_reg <= dividend;
                div_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= CW'(NW);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg  <= fits ? diff[DW-1:0] : trial[DW-1:0];
                work_reg <= {work_reg[NW-2:0], fits};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient    = work_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> dv/gyro_integ_checker.sv
module gyro_integ_checker
    import gaic_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // gyro_raw[15:0], timestamp_us[47:16]
    input  logic [0:0]  s_tuser,   // mode[0]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,   // angle[47:0], bias_offset_q8[71:48]
    input  logic [1:0]  m_tuser,   // in_deadband[0], recalibrated[1]
    input  logic        cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int          mismatches,
    output int          pending
);

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [OFFS_W-1:0]  offset;
        logic               deadband;
        logic               recal;
    } gyro_result_t;

    gyro_result_t angle_q[$];

    longint            angle_acc;
    longint            bias_offs;
    longint            prev_raw;
    logic [TS_W-1:0]   prev_ts;
    longint            bias_sum;
    int unsigned       bias_cnt;
    longint            ref_angle;

    logic [DEADB_W-1:0] deadband;
    logic               autocal;
    logic [CNT_W-1:0]   calib_cnt;
    logic [CNT_W-1:0]   min_bias;

    function automatic longint clamp(input longint v, input int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic longint unsigned magn(input longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    task automatic integrate_sample(input logic mode, input logic [RAW_W-1:0] raw_bits,
                                    input logic [TS_W-1:0] ts);
        gyro_result_t       r;
        longint             raw;
        logic [TS_W-1:0]    dts;
        longint unsigned    dt;
        longint             v1;
        longint             v2;
        longint             s;
        longint unsigned    q;
        longint unsigned    mm;
        longint             mean;
        longint unsigned    drift;
        r.deadband = 1'b0;
        r.recal = 1'b0;
        if (mode == MODE_CLEAR) begin
            angle_acc = 0;
        end
        else begin
            raw = longint'($signed(raw_bits));
            dts = ts - prev_ts;
            dt = (dts > MAX_STEP_US_DEF) ? MAX_STEP_US_DEF : dts;
            v1 = prev_raw * 256 + bias_offs;
            v2 = raw * 256 + bias_offs;
            if (magn(v2) > deadband) begin
                s = v1 + v2;
                // Area (v1+v2)*dt/512, rounded half away from zero.
                q = (magn(s) * dt + 256) >> 9;
                angle_acc = clamp(angle_acc + (s < 0 ? -longint'(q) : longint'(q)), ANGLE_W);
            end
            else begin
                r.deadband = 1'b1;
                bias_sum = clamp(bias_sum + v2, SUM_W);
                if (bias_cnt < 65535) bias_cnt++;
            end
            if (autocal && bias_cnt != 0) begin
                mm = magn(bias_sum) / bias_cnt;
                mean = bias_sum < 0 ? -longint'(mm) : longint'(mm);
                drift = magn(ref_angle - angle_acc);
                if (drift * 256 > mm * 1000000) begin
                    bias_sum = 0;
                    bias_cnt = 0;
                    ref_angle = angle_acc;
                end
                else if (bias_cnt >= calib_cnt && mm > min_bias) begin
                    bias_offs = clamp(bias_offs - mean, OFFS_W);
                    bias_sum = 0;
                    bias_cnt = 0;
                    r.recal = 1'b1;
                end
            end
            prev_raw = raw;
            prev_ts = ts;
        end
        r.angle = angle_acc[ANGLE_W-1:0];
        r.offset = bias_offs[OFFS_W-1:0];
        angle_q.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        gyro_result_t exp_r;
        gyro_result_t got_r;
        if (!rst_n) begin
            angle_acc = 0;
            bias_offs = 0;
            prev_raw = 0;
            prev_ts = '0;
            bias_sum = 0;
            bias_cnt = 0;
            ref_angle = 0;
            deadband = DEADBAND_RST;
            autocal = 1'b0;
            calib_cnt = CALIB_RST;
            min_bias = MIN_BIAS_RST;
            angle_q.delete();
            mismatches = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_DEADBAND: deadband = cfg_data[DEADB_W-1:0];
                    REG_AUTOCAL:
                    begin
                        autocal = cfg_data[0];
                        if (autocal) begin
                            bias_sum = 0;
                            bias_cnt = 0;
                        end
                    end
                    REG_CALIB_COUNT: calib_cnt = cfg_data[CNT_W-1:0];
                    REG_MIN_BIAS: min_bias = cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                integrate_sample(s_tuser[0], s_tdata[15:0], s_tdata[47:16]);
            if (m_tvalid && m_tready) begin
                got_r.angle = m_tdata[47:0];
                got_r.offset = m_tdata[71:48];
                got_r.deadband = m_tuser[0];
                got_r.recal = m_tuser[1];
                if (angle_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result word %h", got_r);
                end
                else begin
                    exp_r = angle_q.pop_front();
                    if (got_r != exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: angle %h/%h offset %h/%h db %b/%b recal %b/%b",
                                     exp_r.angle, got_r.angle, exp_r.offset, got_r.offset,
                                     exp_r.deadband, got_r.deadband, exp_r.recal, got_r.recal);
                    end
                end
            end
        end
        pending = angle_q.size();
    end

endmodule

>>> dv/tb.sv
module tb;
    import gaic_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;    // gyro_raw[15:0], timestamp_us[47:16]
    logic [0:0]  s_tuser = '0;    // mode[0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;         // angle[47:0], bias_offset_q8[71:48]
    logic [1:0]  m_tuser;         // in_deadband[0], recalibrated[1]
    logic        cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int mismatches;
    int pending;
    int cycles = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int mode_left = 0;
    int db_now = 12800;
    logic [31:0] ts = '0;

    gyro_angle_integrator_autocal dut (.*);

    gyro_integ_checker chk (.*);

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver alternates between no stalls, random stalls and long stalls.
    always @(posedge clk)
    begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(128, 512);
        end
        else
            mode_left--;
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (stall_mode == 0)
            m_tready <= 1'b1;
        else if (stall_mode == 1)
            m_tready <= $urandom_range(0, 1);
        else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 30);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_word(input logic mode, input logic [15:0] raw, input logic [31:0] t);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {t, raw};
        // Inputs only change at rising edges, so ready seen at the falling edge holds.
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending != 0);
        repeat (60) @(posedge clk);
    endtask

    task automatic next_ts();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) ts = ts + $urandom_range(1, 2000);
        else if (pick < 85) ts = ts + $urandom_range(0, 1);
        else if (pick < 95) ts = ts + $urandom_range(0, 32'h0020_0000);
        else ts = $urandom;
    endtask

    task automatic run_random(input int n, input int band_pct);
        int band;
        int raw;
        logic mode;
        band = db_now / 256 + 2;
        if (band > 32767) band = 32767;
        repeat (n) begin
            mode = ($urandom_range(0, 29) == 0) ? MODE_CLEAR : MODE_SAMPLE;
            if ($urandom_range(0, 99) < band_pct) raw = $urandom_range(0, 2 * band) - band;
            else raw = $urandom;
            next_ts();
            send_word(mode, raw[15:0], ts);
        end
        wait_idle();
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, timestamp wrap, step saturation, zero crossing, clear.
        send_word(MODE_SAMPLE, 16'h7FFF, 32'd0);
        send_word(MODE_SAMPLE, 16'h7FFF, 32'd1000);
        send_word(MODE_SAMPLE, 16'h8000, 32'd3000);
        send_word(MODE_SAMPLE, 16'h0000, 32'd3001);
        send_word(MODE_SAMPLE, 16'd30, 32'd4000);
        send_word(MODE_SAMPLE, -16'sd30, 32'd5000);
        send_word(MODE_SAMPLE, 16'd1000, 32'hFFFF_FF00);
        send_word(MODE_SAMPLE, -16'sd1000, 32'h0000_0100);
        send_word(MODE_CLEAR, 16'hFFFF, 32'hFFFF_FFFF);
        send_word(MODE_SAMPLE, 16'd51, 32'h0000_0200);
        send_word(MODE_SAMPLE, 16'd50, 32'h0000_0300);
        send_word(MODE_SAMPLE, -16'sd51, 32'h8000_0000);
        send_word(MODE_SAMPLE, 16'h7FFF, 32'h0000_0000);
        for (int i = 0; i < 10; i++)
            send_word(MODE_SAMPLE, 16'h7FFF, 32'h0010_0000 * (i + 1));
        send_word(MODE_CLEAR, 16'h0000, 32'h0000_0000);
        wait_idle();
        ts = 32'h0200_0000;
        run_random(120, 50);

        write_reg(REG_INIT_OFFSET, -8388608);
        write_reg(REG_AUTOCAL, 1);
        write_reg(REG_CALIB_COUNT, 4);
        write_reg(REG_MIN_BIAS, 0);
        run_random(140, 90);

        write_reg(REG_DEADBAND, 0);
        db_now = 0;
        write_reg(REG_CALIB_COUNT, 1);
        write_reg(REG_MIN_BIAS, 65535);
        write_reg(3'd7, 12345);
        run_random(100, 80);

        write_reg(REG_DEADBAND, 8388607);
        db_now = 8388607;
        write_reg(REG_CALIB_COUNT, 65535);
        write_reg(REG_MIN_BIAS, 26);
        write_reg(REG_AUTOCAL, 1);
        run_random(120, 30);

        write_reg(REG_INIT_OFFSET, 8388607);
        write_reg(REG_AUTOCAL, 0);
        write_reg(REG_DEADBAND, 2560);
        db_now = 2560;
        run_random(120, 60);

        write_reg(REG_AUTOCAL, 1);
        write_reg(REG_CALIB_COUNT, 8);
        write_reg(REG_MIN_BIAS, 10);
        write_reg(REG_DEADBAND, 5000);
        db_now = 5000;
        run_random(150, 92);

        write_reg(REG_CALIB_COUNT, 2);
        write_reg(REG_MIN_BIAS, 1);
        write_reg(REG_DEADBAND, 12800);
        db_now = 12800;
        run_random(100, 95);

        if (mismatches == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
